// ----- rtl/cftt_pkg.sv -----
// Package for the CAN / CAN-FD frame transmission time block.
// Holds widths, protocol constants, the decoded-item struct and the CAN-FD length rounding.
// No dependencies.
package cftt_pkg;

  localparam int unsigned SIZE_W  = 12;  // payload size in bytes
  localparam int unsigned BT_W    = 13;  // bit time in ns
  localparam int unsigned FULL_W  = 9;   // number of full frames
  localparam int unsigned PART_W  = 10;  // bit count of the last partial frame
  localparam int unsigned REM_W   = 7;   // CAN-FD remainder, 1..64
  localparam int unsigned COEF_W  = 17;  // total bit count of all frames
  localparam int unsigned FIXED_W = 22;  // fixed CAN-FD time of all frames, ns
  localparam int unsigned PROD_W  = 30;  // bit count times bit time
  localparam int unsigned OUT_W   = 31;  // transmission time in ns

  localparam int unsigned CAN_FULL_BITS = 135;
  localparam int unsigned CAN_BASE_BITS = 55;
  localparam int unsigned FD_FULL_BITS  = 673;
  localparam int unsigned FD_BASE_BITS  = 28;
  localparam int unsigned FD_CRC_BITS   = 5;
  localparam int unsigned FD_FIXED_NS   = 64000;
  localparam int unsigned FD_CRC_LIMIT  = 16;
  localparam int unsigned BYTE_BITS     = 10;

  localparam logic PROTO_CAN = 1'b0;
  localparam logic PROTO_FD  = 1'b1;

  typedef struct packed {
    logic              fd;         // CAN-FD framing
    logic              nz;         // payload is not empty
    logic [FULL_W-1:0] full;       // full frames before the last one
    logic [PART_W-1:0] part_bits;  // bit count of the last frame
  } dec_t;

  // Rounds a partial CAN-FD payload up to the next data length code size.
  function automatic logic [REM_W-1:0] fd_dlc_size(input logic [REM_W-1:0] r);
    logic [REM_W-1:0] a;
    priority if (r <= REM_W'(8)) begin
      a = r;
    end else if (r <= REM_W'(12)) begin
      a = REM_W'(12);
    end else if (r <= REM_W'(16)) begin
      a = REM_W'(16);
    end else if (r <= REM_W'(20)) begin
      a = REM_W'(20);
    end else if (r <= REM_W'(24)) begin
      a = REM_W'(24);
    end else if (r <= REM_W'(32)) begin
      a = REM_W'(32);
    end else if (r <= REM_W'(48)) begin
      a = REM_W'(48);
    end else begin
      a = REM_W'(64);
    end
    return a;
  endfunction

endpackage

// ----- rtl/cftt_decode.sv -----
// First-stage decode: splits a payload into full frames and a last partial frame.
// Depends on cftt_pkg.
module cftt_decode (
  input  logic                        protocol,
  input  logic [cftt_pkg::SIZE_W-1:0] frame_size,
  output cftt_pkg::dec_t              dec
);

  logic [cftt_pkg::SIZE_W-1:0] size_m1;
  logic [3:0]                  can_rem;
  logic [cftt_pkg::REM_W-1:0]  fd_rem;
  logic [cftt_pkg::REM_W-1:0]  fd_a;
  logic                        fd_crc;
  logic [cftt_pkg::PART_W-1:0] can_part;
  logic [cftt_pkg::PART_W-1:0] fd_part;

  // The partial frame holds 1..chunk bytes, so work from size minus one.
  assign size_m1  = frame_size - cftt_pkg::SIZE_W'(1);
  assign can_rem  = {1'b0, size_m1[2:0]} + 4'd1;
  assign fd_rem   = {1'b0, size_m1[5:0]} + cftt_pkg::REM_W'(1);
  assign fd_a     = cftt_pkg::fd_dlc_size(fd_rem);
  assign fd_crc   = (fd_a > cftt_pkg::REM_W'(cftt_pkg::FD_CRC_LIMIT));

  assign can_part = cftt_pkg::PART_W'(cftt_pkg::CAN_BASE_BITS)
                  + cftt_pkg::PART_W'(can_rem) * cftt_pkg::PART_W'(cftt_pkg::BYTE_BITS);
  assign fd_part  = cftt_pkg::PART_W'(cftt_pkg::FD_BASE_BITS)
                  + (fd_crc ? cftt_pkg::PART_W'(cftt_pkg::FD_CRC_BITS) : '0)
                  + cftt_pkg::PART_W'(fd_a) * cftt_pkg::PART_W'(cftt_pkg::BYTE_BITS);

  always_comb begin
    dec.fd = protocol;
    dec.nz = (frame_size != '0);
    if (!dec.nz) begin
      dec.full      = '0;
      dec.part_bits = '0;
    end else if (protocol == cftt_pkg::PROTO_FD) begin
      dec.full      = cftt_pkg::FULL_W'(size_m1[cftt_pkg::SIZE_W-1:6]);
      dec.part_bits = fd_part;
    end else begin
      dec.full      = size_m1[cftt_pkg::SIZE_W-1:3];
      dec.part_bits = can_part;
    end
  end

endmodule

// ----- rtl/can_frame_transmission_time.sv -----
// CAN / CAN-FD frame transmission time, four-stage pipeline.
// Depends on cftt_pkg and cftt_decode.
//
// Each request carries a payload size in bytes, a protocol flag and a bit time in ns, and
// yields one response with the time needed to send that payload as a run of frames. Classic
// CAN uses 8-byte frames of 135 bit times each, with a last frame of r bytes costing 55+10r
// bit times. CAN-FD uses 64-byte frames costing 64000 ns plus 673 bit times each; the last
// frame is rounded up to the next data length size a and costs 64000 ns plus 28+5c+10a bit
// times (c set when a exceeds 16). An empty payload gives zero. Sizes above MAX_FRAME_BYTES
// are treated as MAX_FRAME_BYTES. The block takes one request per clock when the response
// side does not stall; each request passes through decode, bit-count multiply-add,
// multiply by the bit time and the final add into the output register. Every stage
// holds its own valid bit and moves as soon as the stage after it is free, so bubbles close
// up and a held response does not stop requests from filling the empty stages behind it.
// Within the field ranges the result always fits in 31 bits.
module can_frame_transmission_time #(
  parameter int unsigned MAX_FRAME_BYTES = 4095
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [11:0] frame_size, [24:12] bit_time_ns, [31:25] zero
  input  logic        in_tuser,   // [0] protocol (0 classic CAN, 1 CAN-FD)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [30:0] trans_time_ns, [31] zero
);

  localparam logic [15:0] MAX_SIZE = 16'(MAX_FRAME_BYTES);

  // Input fields.
  logic [cftt_pkg::SIZE_W-1:0] in_size;
  logic [cftt_pkg::SIZE_W-1:0] size_clamp;
  logic [cftt_pkg::BT_W-1:0]   in_bt;
  cftt_pkg::dec_t              dec;

  assign in_size    = in_tdata[cftt_pkg::SIZE_W-1:0];
  assign in_bt      = in_tdata[cftt_pkg::SIZE_W +: cftt_pkg::BT_W];
  assign size_clamp = (16'(in_size) > MAX_SIZE) ? cftt_pkg::SIZE_W'(MAX_SIZE) : in_size;

  cftt_decode u_decode (
    .protocol   (in_tuser),
    .frame_size (size_clamp),
    .dec        (dec)
  );

  // Stage valid bits and the ready chain: a stage may load when it is empty or when the
  // stage after it takes its content in this cycle.
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;

  assign s4_rdy    = !s4_vld_r || out_tready;
  assign s3_rdy    = !s3_vld_r || s4_rdy;
  assign s2_rdy    = !s2_vld_r || s3_rdy;
  assign s1_rdy    = !s1_vld_r || s2_rdy;
  assign in_tready = s1_rdy;

  // Stage 1: decoded frame split.
  cftt_pkg::dec_t             s1_dec_r;
  logic [cftt_pkg::BT_W-1:0]  s1_bt_r;

  // Stage 2: total bit count and fixed CAN-FD time.
  logic [cftt_pkg::COEF_W-1:0]  s2_coef_r, s2_coef_nxt;
  logic [cftt_pkg::FIXED_W-1:0] s2_fixed_r, s2_fixed_nxt;
  logic [cftt_pkg::BT_W-1:0]    s2_bt_r;
  logic [cftt_pkg::COEF_W-1:0]  full_bits;
  logic [cftt_pkg::FULL_W:0]    frames;

  // Stage 3: bit time product.
  logic [cftt_pkg::PROD_W-1:0]  s3_prod_r, s3_prod_nxt;
  logic [cftt_pkg::FIXED_W-1:0] s3_fixed_r;

  // Stage 4: output register.
  logic [cftt_pkg::OUT_W-1:0]   s4_time_r, s4_time_nxt;

  always_comb begin
    full_bits = (s1_dec_r.fd == cftt_pkg::PROTO_FD)
              ? cftt_pkg::COEF_W'(s1_dec_r.full) * cftt_pkg::COEF_W'(cftt_pkg::FD_FULL_BITS)
              : cftt_pkg::COEF_W'(s1_dec_r.full) * cftt_pkg::COEF_W'(cftt_pkg::CAN_FULL_BITS);
    s2_coef_nxt = full_bits + cftt_pkg::COEF_W'(s1_dec_r.part_bits);
    // Every CAN-FD frame, the partial one included, adds the fixed time.
    frames = {1'b0, s1_dec_r.full} + (cftt_pkg::FULL_W + 1)'(1);
    if (s1_dec_r.nz && (s1_dec_r.fd == cftt_pkg::PROTO_FD)) begin
      s2_fixed_nxt = cftt_pkg::FIXED_W'(frames) * cftt_pkg::FIXED_W'(cftt_pkg::FD_FIXED_NS);
    end else begin
      s2_fixed_nxt = '0;
    end
    s3_prod_nxt = cftt_pkg::PROD_W'(s2_coef_r) * cftt_pkg::PROD_W'(s2_bt_r);
    s4_time_nxt = cftt_pkg::OUT_W'(s3_prod_r) + cftt_pkg::OUT_W'(s3_fixed_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_vld_r <= in_tvalid;
      end
      if (s2_rdy) begin
        s2_vld_r <= s1_vld_r;
      end
      if (s3_rdy) begin
        s3_vld_r <= s2_vld_r;
      end
      if (s4_rdy) begin
        s4_vld_r <= s3_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_tvalid) begin
      s1_dec_r <= dec;
      s1_bt_r  <= in_bt;
    end
    if (s2_rdy && s1_vld_r) begin
      s2_coef_r  <= s2_coef_nxt;
      s2_fixed_r <= s2_fixed_nxt;
      s2_bt_r    <= s1_bt_r;
    end
    if (s3_rdy && s2_vld_r) begin
      s3_prod_r  <= s3_prod_nxt;
      s3_fixed_r <= s2_fixed_r;
    end
    if (s4_rdy && s3_vld_r) begin
      s4_time_r <= s4_time_nxt;
    end
  end

  assign out_tvalid = s4_vld_r;
  assign out_tdata  = {1'b0, s4_time_r};

endmodule

// ----- rtl/cftt_checker.sv -----
// Port-level checks for the CAN / CAN-FD frame transmission time block, and its bind.
// Depends on can_frame_transmission_time.
module cftt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // A held response keeps its valid.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("response valid dropped while stalled");

  // A held response keeps its data.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("response data changed while stalled");

  // When the output register is free or draining, the pipeline takes a request.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("request refused while the output side is free");

  // Reset empties the pipeline.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("response valid after reset");

endmodule

bind can_frame_transmission_time cftt_checker u_cftt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
